FILE: rtl/core/drpr_pkg.sv
package drpr_pkg;

	localparam int TimerBitsDefault = 16;
	localparam int RegBits = 16;
	localparam int RetryBits = 4;
	localparam int CfgIndexBits = 2;

	localparam logic [RegBits-1:0] PulseTicksReset = 16'd1000;
	localparam logic [RegBits-1:0] CheckTicksReset = 16'd3000;
	localparam logic [RetryBits-1:0] MaxRetriesReset = 4'd5;

	typedef enum logic [CfgIndexBits-1:0] {
		CFG_PULSE_TICKS = 2'd0,
		CFG_CHECK_TICKS = 2'd1,
		CFG_MAX_RETRIES = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		POS_CLOSED     = 2'd0,
		POS_OPENED     = 2'd1,
		POS_UNKNOWN    = 2'd2,
		POS_INCOHERENT = 2'd3
	} door_pos_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_STARTED  = 3'd1,
		EV_AWAIT    = 3'd2,
		EV_NO_CHECK = 3'd3,
		EV_MOVED    = 3'd4,
		EV_RETRY    = 3'd5,
		EV_GAVE_UP  = 3'd6
	} garage_event_t;

	typedef struct packed {
		logic opened_level;
		logic closed_level;
		logic garage_request;
		logic gate_request;
	} tick_t;

	typedef struct packed {
		logic [1:0]           door_position;
		logic                 position_changed;
		logic                 garage_relay_on;
		logic                 gate_relay_on;
		logic [2:0]           garage_event;
		logic [RetryBits-1:0] retry_number;
		logic                 gate_done;
	} status_t;

	typedef struct packed {
		logic [RegBits-1:0]   relay_pulse_ticks;
		logic [RegBits-1:0]   check_wait_ticks;
		logic [RetryBits-1:0] max_retries;
	} cfg_t;

	typedef struct packed {
		door_pos_t            position;
		logic                 changed;
		logic                 relay_on;
		garage_event_t        event_code;
		logic [RetryBits-1:0] retries;
	} garage_status_t;

	typedef struct packed {
		logic relay_on;
		logic done;
	} gate_status_t;

	function automatic door_pos_t decode_position(input logic opened, input logic closed);
		door_pos_t p;
		case ({opened, closed})
			2'b10:   p = POS_OPENED;
			2'b01:   p = POS_CLOSED;
			2'b00:   p = POS_UNKNOWN;
			default: p = POS_INCOHERENT;
		endcase
		return p;
	endfunction

endpackage

FILE: rtl/core/drpr_stream_if.sv
interface drpr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/drpr_gate.sv
module drpr_gate
	import drpr_pkg::*;
#(
	parameter int TIMER_BITS = TimerBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               request,
	input  logic [RegBits-1:0] pulse_ticks,
	output gate_status_t       status
);
	localparam int CmpBits = (TIMER_BITS > RegBits) ? TIMER_BITS : RegBits;
	localparam logic [CmpBits-1:0] TmaxExt = CmpBits'({TIMER_BITS{1'b1}});

	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
	logic                  active_q, active_d;
	logic [CmpBits-1:0]    limit_ext, limit_eff;
	logic                  expired;

	always_comb begin
		timer_inc = (timer_q == {TIMER_BITS{1'b1}}) ? timer_q : timer_q + 1'b1;
		limit_ext = CmpBits'(pulse_ticks);
		limit_eff = (limit_ext > TmaxExt) ? TmaxExt : limit_ext;
		expired = CmpBits'(timer_inc) >= limit_eff;
	end

	always_comb begin
		timer_d = timer_q;
		active_d = active_q;
		status.done = 1'b0;
		if (active_q) begin
			timer_d = timer_inc;
			if (expired) begin
				active_d = 1'b0;
				status.done = 1'b1;
			end
		end else if (request) begin
			active_d = 1'b1;
			timer_d = '0;
		end
		status.relay_on = active_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			timer_q <= '0;
		end else if (adv) begin
			active_q <= active_d;
			timer_q <= timer_d;
		end
	end
endmodule

FILE: rtl/core/drpr_garage.sv
module drpr_garage
	import drpr_pkg::*;
#(
	parameter int TIMER_BITS = TimerBitsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  tick_t          item,
	input  cfg_t           cfg,
	output garage_status_t status
);
	localparam int CmpBits = (TIMER_BITS > RegBits) ? TIMER_BITS : RegBits;
	localparam logic [CmpBits-1:0] TmaxExt = CmpBits'({TIMER_BITS{1'b1}});

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PULSE = 3'b010,
		PH_CHECK = 3'b100
	} phase_t;

	phase_t                phase_q, phase_d;
	door_pos_t             last_pos_q, start_pos_q, start_pos_d, pos;
	logic                  first_q;
	logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
	logic [RetryBits-1:0]  retries_q, retries_d;
	logic [CmpBits-1:0]    limit_ext, limit_eff;
	logic                  expired;
	logic                  start_at_end;
	garage_event_t         ev;

	always_comb begin
		pos = decode_position(item.opened_level, item.closed_level);
		timer_inc = (timer_q == {TIMER_BITS{1'b1}}) ? timer_q : timer_q + 1'b1;
		limit_ext = (phase_q == PH_CHECK) ? CmpBits'(cfg.check_wait_ticks)
			: CmpBits'(cfg.relay_pulse_ticks);
		limit_eff = (limit_ext > TmaxExt) ? TmaxExt : limit_ext;
		expired = CmpBits'(timer_inc) >= limit_eff;
		start_at_end = (start_pos_q == POS_CLOSED) || (start_pos_q == POS_OPENED);
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		retries_d = retries_q;
		start_pos_d = start_pos_q;
		ev = EV_NONE;
		if (item.garage_request) begin
			retries_d = '0;
			start_pos_d = pos;
			timer_d = '0;
			phase_d = PH_PULSE;
			ev = EV_STARTED;
		end else begin
			unique case (phase_q)
				PH_PULSE: begin
					timer_d = timer_inc;
					if (expired) begin
						if (start_at_end) begin
							timer_d = '0;
							phase_d = PH_CHECK;
							ev = EV_AWAIT;
						end else begin
							phase_d = PH_IDLE;
							ev = EV_NO_CHECK;
						end
					end
				end
				PH_CHECK: begin
					timer_d = timer_inc;
					if (expired) begin
						if (pos != start_pos_q) begin
							phase_d = PH_IDLE;
							ev = EV_MOVED;
						end else if (retries_q < cfg.max_retries) begin
							retries_d = retries_q + 1'b1;
							timer_d = '0;
							phase_d = PH_PULSE;
							ev = EV_RETRY;
						end else begin
							phase_d = PH_IDLE;
							ev = EV_GAVE_UP;
						end
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		status.position = pos;
		status.changed = first_q || (pos != last_pos_q);
		status.relay_on = (phase_d == PH_PULSE);
		status.event_code = ev;
		status.retries = retries_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= 1'b1;
			last_pos_q <= POS_CLOSED;
			start_pos_q <= POS_UNKNOWN;
			timer_q <= '0;
			retries_q <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			first_q <= 1'b0;
			last_pos_q <= pos;
			start_pos_q <= start_pos_d;
			timer_q <= timer_d;
			retries_q <= retries_d;
		end
	end
endmodule

FILE: rtl/core/door_relay_pulse_retry_controller.sv
// Door relay pulse and retry controller.
// tick: one item per timer tick with the debounced open/closed sensor levels
//   and one-tick garage and gate requests.
// status: one result item per tick item: decoded door position, change flag,
//   both relay drives, the garage sequence event, retry count and gate done.
// cfg_we/cfg_index/cfg_wdata: register writes (pulse ticks, check wait ticks,
//   max retries); the user must write only while no item is in flight, which the block does not enforce.
// Pipeline: tick item registered in s1, state update and result computed in
//   one pass from s1 into the status register. Throughput is one item per
//   cycle while status is taken, as the garage sequencer and gate timer
//   update their state in that one pass.
// Stall: when status is not taken, the status register holds its item, s1
//   holds the next one, and tick.ready drops while both are full.
// Reset: registers return to 1000/3000 ticks and 5 retries, the sequencer goes
//   idle, the gate relay is off and the first result flags a position change.
module door_relay_pulse_retry_controller
	import drpr_pkg::*;
#(
	parameter int TIMER_BITS = TimerBitsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	drpr_stream_if.sink             tick,
	drpr_stream_if.source           status,
	input  logic                    cfg_we,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [RegBits-1:0]      cfg_wdata
);
	cfg_t           cfg_q;
	tick_t          item_s1;
	logic           valid_s1;
	logic           adv;
	status_t        out_q;
	logic           out_valid_q;
	garage_status_t garage;
	gate_status_t   gate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relay_pulse_ticks <= PulseTicksReset;
			cfg_q.check_wait_ticks <= CheckTicksReset;
			cfg_q.max_retries <= MaxRetriesReset;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PULSE_TICKS: cfg_q.relay_pulse_ticks <= cfg_wdata;
				CFG_CHECK_TICKS: cfg_q.check_wait_ticks <= cfg_wdata;
				CFG_MAX_RETRIES: cfg_q.max_retries <= cfg_wdata[RetryBits-1:0];
				default: ;
			endcase
		end
	end

	// s1 moves into the status register when that is empty or being drained
	assign adv = valid_s1 && (!out_valid_q || status.ready);
	assign tick.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= tick.data;
		end
	end

	drpr_garage #(
		.TIMER_BITS(TIMER_BITS)
	) u_garage (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.item(item_s1),
		.cfg(cfg_q),
		.status(garage)
	);

	drpr_gate #(
		.TIMER_BITS(TIMER_BITS)
	) u_gate (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.request(item_s1.gate_request),
		.pulse_ticks(cfg_q.relay_pulse_ticks),
		.status(gate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.door_position <= garage.position;
			out_q.position_changed <= garage.changed;
			out_q.garage_relay_on <= garage.relay_on;
			out_q.gate_relay_on <= gate.relay_on;
			out_q.garage_event <= garage.event_code;
			out_q.retry_number <= garage.retries;
			out_q.gate_done <= gate.done;
		end
	end

	assign status.valid = out_valid_q;
	assign status.data = out_q;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("s1 item dropped while output stalled");

	a_gate_done_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.gate_done |-> !out_q.gate_relay_on)
		else $error("gate relay still on when gate pulse ended");

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.garage_event == EV_STARTED)
		|-> out_q.garage_relay_on && (out_q.retry_number == '0))
		else $error("garage start without fresh pulse");

	a_end_relay_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((out_q.garage_event == EV_MOVED)
		|| (out_q.garage_event == EV_GAVE_UP) || (out_q.garage_event == EV_NO_CHECK)
		|| (out_q.garage_event == EV_AWAIT))
		|-> !out_q.garage_relay_on)
		else $error("garage relay on after pulse end");

	a_retry_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.garage_event == EV_RETRY)
		|-> out_q.garage_relay_on && (out_q.retry_number != '0))
		else $error("retry without pulse or count");
endmodule
